>>> sv/fcr_pkg.sv
// Shared types, constants and helpers for the frame count resampler.
package fcr_pkg;

    localparam int COEFS_PER_FRAME_DEF = 26;
    localparam int CNT_W = 9;
    localparam int COEF_W = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_SPACING = 2'd2;

    // Register reset values
    localparam logic [CNT_W-1:0] TARGET_FRAMES_RST = 9'd60;
    localparam logic [CNT_W-1:0] SOURCE_FRAMES_RST = 9'd60;
    localparam logic [CNT_W-1:0] EVENT_SPACING_RST = 9'd1;

    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_MERGE  = 2'd1,
        PEND_INSERT = 2'd2
    } pend_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_in;
        logic                     sequence_start;
    } in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_out;
        logic                     frame_end;
        logic                     sequence_end;
        logic                     last_of_run;
    } out_t;

    // Saturating add for the row and frame counters (limit 511)
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // floor((a+b)/2) on signed Q7.8, always fits in 16 bits
    function automatic logic signed [COEF_W-1:0] avg(input logic signed [COEF_W-1:0] a,
                                                     input logic signed [COEF_W-1:0] b);
        logic signed [COEF_W:0] s;
        s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        return s[COEF_W:1];
    endfunction

endpackage

>>> sv/frame_count_resampler_top.sv
// Top level of the frame count resampler: sequencer plus the two frame stores.
//
// Usage: coefficients stream in on in_valid/in_ready/in_data, COEFS_PER_FRAME
// per frame, with sequence_start set on the first coefficient of a sequence.
// Results leave on out_valid/out_ready/out_data; each transfer carries one
// coefficient and frame_end, sequence_end and last_of_run flags.
// Configuration (target_frames, source_frames, event_spacing) is written through
// cfg_wr_en/cfg_index/cfg_data; the user must write it only while the block is
// idle (the block itself does not enforce this); writes take effect at once.
// Flow: an item's held-frame read is issued at accept, then the compute state
// computes and writes back, waiting while the output register is full; a new
// item is accepted only once the last one is through. After the last coefficient
// of a row following an insertion point the stored incoming frame is replayed
// unless the target is reached, alternating a read state and an output state per
// coefficient. The compute state loads its result into the output register.
// Reset: counters clear, nothing is pending, registers return to 60/60/1; the
// frame stores are not cleared and need no clearing pass.
// Stall: a result waits in the output register; while it waits the block may
// accept the next item and finish its memory read, then holds until the
// output register frees up.
module frame_count_resampler_top #(
    parameter int COEFS_PER_FRAME = fcr_pkg::COEFS_PER_FRAME_DEF,
    localparam int PW = (COEFS_PER_FRAME > 1) ? $clog2(COEFS_PER_FRAME) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcr_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fcr_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fcr_pkg::out_t                 out_data
);

    logic                              held_we, held_re, inc_we, inc_re;
    logic [PW-1:0]                     held_waddr, held_raddr, inc_waddr, inc_raddr;
    logic signed [fcr_pkg::COEF_W-1:0] held_wdata, held_rdata, inc_wdata, inc_rdata;

    // Control and datapath
    fcr_seq #(
        .COEFS_PER_FRAME(COEFS_PER_FRAME)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .held_we    (held_we),
        .held_waddr (held_waddr),
        .held_wdata (held_wdata),
        .held_re    (held_re),
        .held_raddr (held_raddr),
        .held_rdata (held_rdata),
        .inc_we     (inc_we),
        .inc_waddr  (inc_waddr),
        .inc_wdata  (inc_wdata),
        .inc_re     (inc_re),
        .inc_raddr  (inc_raddr),
        .inc_rdata  (inc_rdata)
    );

    // Previous source row
    fcr_frame_mem #(
        .DEPTH(COEFS_PER_FRAME)
    ) u_held_mem (
        .clk   (clk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .re    (held_re),
        .raddr (held_raddr),
        .rdata (held_rdata)
    );

    // Row following an insertion point
    fcr_frame_mem #(
        .DEPTH(COEFS_PER_FRAME)
    ) u_inc_mem (
        .clk   (clk),
        .we    (inc_we),
        .waddr (inc_waddr),
        .wdata (inc_wdata),
        .re    (inc_re),
        .raddr (inc_raddr),
        .rdata (inc_rdata)
    );

endmodule

>>> sv/fcr_frame_mem.sv
// One-frame coefficient store: single write port, one registered read port.
module fcr_frame_mem #(
    parameter int DEPTH = fcr_pkg::COEFS_PER_FRAME_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic signed [fcr_pkg::COEF_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic signed [fcr_pkg::COEF_W-1:0] rdata
);

    logic signed [fcr_pkg::COEF_W-1:0] mem [DEPTH];
    logic signed [fcr_pkg::COEF_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fcr_seq.sv
// Sequencer: counters, merge/insert decisions, averaging and the output register.
module fcr_seq #(
    parameter int COEFS_PER_FRAME = fcr_pkg::COEFS_PER_FRAME_DEF,
    localparam int PW = (COEFS_PER_FRAME > 1) ? $clog2(COEFS_PER_FRAME) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcr_pkg::CNT_W-1:0]         cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fcr_pkg::in_t                      in_data,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output fcr_pkg::out_t                     out_data,
    // held frame memory
    output logic                              held_we,
    output logic [PW-1:0]                     held_waddr,
    output logic signed [fcr_pkg::COEF_W-1:0] held_wdata,
    output logic                              held_re,
    output logic [PW-1:0]                     held_raddr,
    input  logic signed [fcr_pkg::COEF_W-1:0] held_rdata,
    // incoming frame memory
    output logic                              inc_we,
    output logic [PW-1:0]                     inc_waddr,
    output logic signed [fcr_pkg::COEF_W-1:0] inc_wdata,
    output logic                              inc_re,
    output logic [PW-1:0]                     inc_raddr,
    input  logic signed [fcr_pkg::COEF_W-1:0] inc_rdata
);

    localparam int CW = fcr_pkg::CNT_W;
    localparam logic [PW-1:0] POS_LAST = PW'(COEFS_PER_FRAME - 1);

    fcr_pkg::state_t state_reg, state_next;

    logic [CW-1:0] target_reg, source_reg, spacing_reg;
    logic [PW-1:0] coef_position_reg, coef_position_next;
    logic [CW-1:0] source_row_reg, source_row_next;
    logic [CW-1:0] next_event_row_reg, next_event_row_next;
    logic [CW-1:0] events_done_reg, events_done_next;
    logic [CW-1:0] frames_emitted_reg, frames_emitted_next;
    fcr_pkg::pend_t pending_reg, pending_next;
    logic [PW-1:0] drain_idx_reg, drain_idx_next;
    logic signed [fcr_pkg::COEF_W-1:0] coef_reg;

    logic          out_valid_reg, out_valid_next;
    fcr_pkg::out_t out_data_reg, out_data_next;

    // FSM outputs
    logic accept, calc_fire, drain_fire, out_free;

    // Datapath decisions
    logic          accept_pos_zero;
    logic          is_last, reduce, insert, event_row, emit_req, emit_ok;
    logic          fe_calc, drain_go, drain_emit, drain_fe;
    logic [CW-1:0] diff;
    logic [CW-1:0] fem_after;
    fcr_pkg::pend_t np;
    fcr_pkg::out_t calc_out, drain_out;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcr_pkg::ST_IDLE:
                if (in_valid)
                    state_next = fcr_pkg::ST_CALC;
            fcr_pkg::ST_CALC:
                if (out_free)
                    state_next = drain_go ? fcr_pkg::ST_DRAIN_RD : fcr_pkg::ST_IDLE;
            fcr_pkg::ST_DRAIN_RD:
                state_next = fcr_pkg::ST_DRAIN_OUT;
            fcr_pkg::ST_DRAIN_OUT:
                if (out_free)
                    state_next = (drain_idx_reg == POS_LAST) ? fcr_pkg::ST_IDLE
                                                             : fcr_pkg::ST_DRAIN_RD;
            default:
                state_next = fcr_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready   = 1'b0;
        calc_fire  = 1'b0;
        inc_re     = 1'b0;
        drain_fire = 1'b0;
        unique case (state_reg)
            fcr_pkg::ST_IDLE:      in_ready   = 1'b1;
            fcr_pkg::ST_CALC:      calc_fire  = out_free;
            fcr_pkg::ST_DRAIN_RD:  inc_re     = 1'b1;
            fcr_pkg::ST_DRAIN_OUT: drain_fire = out_free;
            default:               in_ready   = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    // Position of the coefficient being taken, after a sequence clear or wrap
    assign accept_pos_zero = in_data.sequence_start ||
        ({1'b0, coef_position_reg} >= (PW+1)'(COEFS_PER_FRAME));

    // Held frame: read at accept, written when the item completes
    assign held_re    = accept;
    assign held_raddr = accept_pos_zero ? '0 : coef_position_reg;
    assign held_we    = calc_fire;
    assign held_waddr = coef_position_reg;
    assign held_wdata = coef_reg;

    // Incoming frame: captured during a pending insert, replayed in the drain
    assign inc_we    = calc_fire && (pending_reg == fcr_pkg::PEND_INSERT);
    assign inc_waddr = coef_position_reg;
    assign inc_wdata = coef_reg;
    assign inc_raddr = drain_idx_reg;

    // Merge / insertion point detection
    assign reduce = target_reg < source_reg;
    assign insert = target_reg > source_reg;
    assign diff   = insert ? (target_reg - source_reg) : (source_reg - target_reg);
    assign event_row = (source_row_reg == next_event_row_reg) &&
                       (events_done_reg < diff) &&
                       (({1'b0, source_row_reg} + (CW+1)'(1)) < {1'b0, source_reg});
    assign is_last = (coef_position_reg == POS_LAST);

    // Result of the current item
    always_comb
    begin
        emit_req = (pending_reg != fcr_pkg::PEND_NONE) || !(reduce && event_row);
        emit_ok  = emit_req && (frames_emitted_reg < target_reg);
        fe_calc  = is_last;
        fem_after = (emit_ok && fe_calc) ? fcr_pkg::sat_add(frames_emitted_reg, CW'(1))
                                         : frames_emitted_reg;
        drain_go = (pending_reg == fcr_pkg::PEND_INSERT) && is_last &&
                   (fem_after < target_reg);
        calc_out.coef_out     = (pending_reg != fcr_pkg::PEND_NONE)
                              ? fcr_pkg::avg(held_rdata, coef_reg) : coef_reg;
        calc_out.frame_end    = fe_calc;
        calc_out.sequence_end = fe_calc &&
            (({1'b0, frames_emitted_reg} + (CW+1)'(1)) == {1'b0, target_reg});
        calc_out.last_of_run  = !drain_go;
    end

    // Replayed incoming frame
    always_comb
    begin
        drain_fe   = (drain_idx_reg == POS_LAST);
        drain_emit = frames_emitted_reg < target_reg;
        drain_out.coef_out     = inc_rdata;
        drain_out.frame_end    = drain_fe;
        drain_out.sequence_end = drain_fe &&
            (({1'b0, frames_emitted_reg} + (CW+1)'(1)) == {1'b0, target_reg});
        drain_out.last_of_run  = drain_fe;
    end

    // Next pending kind at the end of a row
    always_comb
    begin
        np = fcr_pkg::PEND_NONE;
        if (pending_reg != fcr_pkg::PEND_MERGE)
        begin
            if (reduce && (pending_reg == fcr_pkg::PEND_NONE) && event_row)
                np = fcr_pkg::PEND_MERGE;
            else if (insert && event_row)
                np = fcr_pkg::PEND_INSERT;
        end
    end

    // Counter next values
    always_comb
    begin
        coef_position_next  = coef_position_reg;
        source_row_next     = source_row_reg;
        next_event_row_next = next_event_row_reg;
        events_done_next    = events_done_reg;
        frames_emitted_next = frames_emitted_reg;
        pending_next        = pending_reg;
        drain_idx_next      = drain_idx_reg;
        if (accept)
        begin
            if (in_data.sequence_start)
            begin
                source_row_next     = '0;
                next_event_row_next = '0;
                events_done_next    = '0;
                frames_emitted_next = '0;
                pending_next        = fcr_pkg::PEND_NONE;
            end
            if (accept_pos_zero)
                coef_position_next = '0;
        end
        else if (calc_fire)
        begin
            frames_emitted_next = fem_after;
            drain_idx_next      = '0;
            if (is_last)
            begin
                if (np != fcr_pkg::PEND_NONE)
                begin
                    events_done_next    = fcr_pkg::sat_add(events_done_reg, CW'(1));
                    next_event_row_next = fcr_pkg::sat_add(next_event_row_reg, spacing_reg);
                end
                pending_next       = np;
                source_row_next    = fcr_pkg::sat_add(source_row_reg, CW'(1));
                coef_position_next = '0;
            end
            else
            begin
                coef_position_next = coef_position_reg + PW'(1);
            end
        end
        else if (drain_fire)
        begin
            if (drain_emit && drain_fe)
                frames_emitted_next = fcr_pkg::sat_add(frames_emitted_reg, CW'(1));
            if (!drain_fe)
                drain_idx_next = drain_idx_reg + PW'(1);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (calc_fire && emit_ok)
        begin
            out_valid_next = 1'b1;
            out_data_next  = calc_out;
        end
        else if (drain_fire && drain_emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = drain_out;
        end
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= fcr_pkg::ST_IDLE;
            coef_position_reg  <= '0;
            source_row_reg     <= '0;
            next_event_row_reg <= '0;
            events_done_reg    <= '0;
            frames_emitted_reg <= '0;
            pending_reg        <= fcr_pkg::PEND_NONE;
            drain_idx_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            coef_position_reg  <= coef_position_next;
            source_row_reg     <= source_row_next;
            next_event_row_reg <= next_event_row_next;
            events_done_reg    <= events_done_next;
            frames_emitted_reg <= frames_emitted_next;
            pending_reg        <= pending_next;
            drain_idx_reg      <= drain_idx_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= fcr_pkg::TARGET_FRAMES_RST;
            source_reg  <= fcr_pkg::SOURCE_FRAMES_RST;
            spacing_reg <= fcr_pkg::EVENT_SPACING_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fcr_pkg::CFG_TARGET_FRAMES: target_reg  <= cfg_data;
                fcr_pkg::CFG_SOURCE_FRAMES: source_reg  <= cfg_data;
                fcr_pkg::CFG_EVENT_SPACING: spacing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            coef_reg <= in_data.coef_in;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A replay only follows the last coefficient of a row with an insert pending
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcr_pkg::ST_CALC && state_next == fcr_pkg::ST_DRAIN_RD) |->
        (pending_reg == fcr_pkg::PEND_INSERT && is_last))
        else $error("replay started without a pending insert");

    // A completed merge never leaves another merge pending
    a_merge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (calc_fire && is_last && pending_reg == fcr_pkg::PEND_MERGE) |=>
        (pending_reg == fcr_pkg::PEND_NONE))
        else $error("merge followed by a pending event");

    // Replay walks the incoming frame one entry per transfer
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_fire && drain_idx_reg != POS_LAST) |=>
        (drain_idx_reg == $past(drain_idx_reg) + PW'(1)))
        else $error("replay index skipped");

    // The held frame is read only while no row update is in flight
    a_held_order: assert property (@(posedge clk) disable iff (!rst_n)
        held_re |-> !held_we && !inc_we)
        else $error("held frame read overlaps a write");

endmodule
